// ===== src/swsr_pkg.sv =====
// Shared types and constants for the single-wire sensor reader.
`default_nettype none

package swsr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESP_FIRST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESP_SECOND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_SAMPLE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES       = 3'd5;

  // register reset values
  localparam logic [15:0] RST_START_LOW   = 16'd1200;
  localparam logic [7:0]  RST_RELEASE     = 8'd20;
  localparam logic [7:0]  RST_RESP_FIRST  = 8'd40;
  localparam logic [7:0]  RST_RESP_SECOND = 8'd80;
  localparam logic [7:0]  RST_BIT_SAMPLE  = 8'd40;
  localparam logic [3:0]  RST_BYTES       = 4'd5;

  // response status codes
  localparam logic [1:0] STAT_NONE  = 2'd0;
  localparam logic [1:0] STAT_OK    = 2'd1;
  localparam logic [1:0] STAT_FAULT = 2'd2;

  typedef struct packed {
    logic [15:0] start_low_ticks;
    logic [7:0]  release_ticks;
    logic [7:0]  response_first_ticks;
    logic [7:0]  response_second_ticks;
    logic [7:0]  bit_sample_ticks;
    logic [3:0]  bytes_per_frame;
  } cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       status_valid;
    logic [1:0] response_status;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       byte_last;
  } res_t;

endpackage

`default_nettype wire

// ===== src/swsr_in_if.sv =====
// Input word channel: one sampled tick of the data line.
`default_nettype none

interface swsr_in_if;
  logic valid;
  logic ready;
  logic line_level;
  logic start_request;

  modport source (output valid, output line_level, output start_request, input ready);
  modport sink   (input valid, input line_level, input start_request, output ready);
endinterface

`default_nettype wire

// ===== src/swsr_out_if.sv =====
// Result word channel: line drive, status and received bytes for one tick.
`default_nettype none

interface swsr_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       status_valid;
  logic [1:0] response_status;
  logic       byte_valid;
  logic [7:0] byte_value;
  logic       byte_last;

  modport source (output valid, output drive_low, output busy_res, output status_valid,
                  output response_status, output byte_valid, output byte_value,
                  output byte_last, input ready);
  modport sink   (input valid, input drive_low, input busy_res, input status_valid,
                  input response_status, input byte_valid, input byte_value,
                  input byte_last, output ready);
endinterface

`default_nettype wire

// ===== src/swsr_cfg_if.sv =====
// Configuration write channel: register index and write data.
`default_nettype none

interface swsr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/swsr_cfg.sv =====
// Configuration register file for the sensor reader.
`default_nettype none

module swsr_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             wr_en,
  input  wire logic [swsr_pkg::CFG_IDX_W-1:0]   wr_idx,
  input  wire logic [swsr_pkg::CFG_DATA_W-1:0]  wr_data,
  output swsr_pkg::cfg_t                        cfg
);
  import swsr_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_idx)
        REG_START_LOW:   cfg_nxt.start_low_ticks       = wr_data;
        REG_RELEASE:     cfg_nxt.release_ticks         = wr_data[7:0];
        REG_RESP_FIRST:  cfg_nxt.response_first_ticks  = wr_data[7:0];
        REG_RESP_SECOND: cfg_nxt.response_second_ticks = wr_data[7:0];
        REG_BIT_SAMPLE:  cfg_nxt.bit_sample_ticks      = wr_data[7:0];
        REG_BYTES:       cfg_nxt.bytes_per_frame       = wr_data[3:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_low_ticks       <= RST_START_LOW;
      cfg_r.release_ticks         <= RST_RELEASE;
      cfg_r.response_first_ticks  <= RST_RESP_FIRST;
      cfg_r.response_second_ticks <= RST_RESP_SECOND;
      cfg_r.bit_sample_ticks      <= RST_BIT_SAMPLE;
      cfg_r.bytes_per_frame       <= RST_BYTES;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== src/swsr_seq.sv =====
// Transaction sequencer: phase, tick timer and bit shifter, stepped once per tick.
`default_nettype none

module swsr_seq #(
  parameter int MAX_BYTES = 8
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step,
  input  wire logic      line_level,
  input  wire logic      start_request,
  input  swsr_pkg::cfg_t cfg,
  output swsr_pkg::res_t res
);
  import swsr_pkg::*;

  localparam int BIW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CW  = $clog2(MAX_BYTES + 1);
  localparam int LW  = (CW > 4) ? CW : 4;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_BYTES);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_LOW, PH_RELEASE, PH_RESP_FIRST, PH_RESP_SECOND,
    PH_RESP_END, PH_WAIT_HIGH, PH_BIT_DELAY, PH_WAIT_LOW
  } phase_t;

  phase_t         phase_r, phase_nxt;
  logic [15:0]    tick_r, tick_nxt;
  logic [7:0]     shift_r, shift_nxt;
  logic [2:0]     bit_idx_r, bit_idx_nxt;
  logic [BIW-1:0] byte_idx_r, byte_idx_nxt;

  logic [15:0]    limit;
  logic           expired;
  logic [LW-1:0]  frame_len;
  logic [LW-1:0]  byte_count;

  // timer limit for the current phase
  always_comb begin
    case (phase_r)
      PH_START_LOW:   limit = cfg.start_low_ticks;
      PH_RELEASE:     limit = {8'd0, cfg.release_ticks};
      PH_RESP_FIRST:  limit = {8'd0, cfg.response_first_ticks};
      PH_RESP_SECOND: limit = {8'd0, cfg.response_second_ticks};
      PH_BIT_DELAY:   limit = {8'd0, cfg.bit_sample_ticks};
      default:        limit = 16'd0;
    endcase
  end

  assign expired = (tick_r >= limit);

  always_comb begin
    if (cfg.bytes_per_frame == 4'd0)
      frame_len = LW'(1);
    else if (LW'(cfg.bytes_per_frame) > MAX_LEN)
      frame_len = MAX_LEN;
    else
      frame_len = LW'(cfg.bytes_per_frame);
  end

  assign byte_count = LW'(byte_idx_r) + LW'(1);

  always_comb begin
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    shift_nxt     = shift_r;
    bit_idx_nxt   = bit_idx_r;
    byte_idx_nxt  = byte_idx_r;
    res           = '0;

    case (phase_r)
      PH_IDLE: begin
        if (start_request) begin
          phase_nxt     = PH_START_LOW;
          tick_nxt      = 16'd1;
          shift_nxt     = 8'd0;
          bit_idx_nxt   = 3'd0;
          byte_idx_nxt  = '0;
        end
      end
      PH_START_LOW: begin
        if (expired) begin
          phase_nxt = PH_RELEASE;
          tick_nxt  = 16'd1;
        end else begin
          tick_nxt = tick_r + 16'd1;
        end
      end
      PH_RELEASE: begin
        if (expired) begin
          phase_nxt = PH_RESP_FIRST;
          tick_nxt  = 16'd1;
        end else begin
          tick_nxt = tick_r + 16'd1;
        end
      end
      PH_RESP_FIRST: begin
        if (expired) begin
          if (!line_level) begin
            phase_nxt     = PH_RESP_SECOND;
            tick_nxt      = 16'd1;
          end else begin
            res.status_valid    = 1'b1;
            res.response_status = STAT_NONE;
            phase_nxt           = PH_IDLE;
            tick_nxt            = 16'd0;
          end
        end else begin
          tick_nxt = tick_r + 16'd1;
        end
      end
      PH_RESP_SECOND: begin
        if (expired) begin
          res.status_valid = 1'b1;
          tick_nxt         = 16'd0;
          if (line_level) begin
            res.response_status = STAT_OK;
            phase_nxt           = PH_RESP_END;
          end else begin
            res.response_status = STAT_FAULT;
            phase_nxt           = PH_IDLE;
          end
        end else begin
          tick_nxt = tick_r + 16'd1;
        end
      end
      PH_RESP_END: begin
        if (!line_level) phase_nxt = PH_WAIT_HIGH;
      end
      PH_WAIT_HIGH: begin
        if (line_level) begin
          phase_nxt = PH_BIT_DELAY;
          tick_nxt  = 16'd1;
        end
      end
      PH_BIT_DELAY: begin
        if (expired) begin
          shift_nxt = {shift_r[6:0], line_level};
          phase_nxt = PH_WAIT_LOW;
          tick_nxt  = 16'd0;
        end else begin
          tick_nxt = tick_r + 16'd1;
        end
      end
      PH_WAIT_LOW: begin
        if (!line_level) begin
          if (bit_idx_r == 3'd7) begin
            res.byte_valid = 1'b1;
            res.byte_value = shift_r;
            bit_idx_nxt    = 3'd0;
            shift_nxt      = 8'd0;
            if (byte_count >= frame_len) begin
              res.byte_last = 1'b1;
              byte_idx_nxt  = '0;
              phase_nxt     = PH_IDLE;
            end else begin
              byte_idx_nxt = byte_idx_r + BIW'(1);
              phase_nxt    = PH_WAIT_HIGH;
            end
          end else begin
            bit_idx_nxt = bit_idx_r + 3'd1;
            phase_nxt   = PH_WAIT_HIGH;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        tick_nxt  = 16'd0;
      end
    endcase

    res.drive_low = (phase_nxt == PH_START_LOW);
    res.busy_res  = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= 16'd0;
      shift_r     <= 8'd0;
      bit_idx_r   <= 3'd0;
      byte_idx_r  <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      shift_r     <= shift_nxt;
      bit_idx_r   <= bit_idx_nxt;
      byte_idx_r  <= byte_idx_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/single_wire_sensor_reader.sv =====
// Top level of the single-wire sensor reader.
`default_nettype none

// Master side of a single-wire sensor exchange, one input word per microsecond tick.
// Each accepted word (line level, start request) advances the sequencer by one tick
// and yields exactly one result word, registered and shown on out_ch in the cycle
// after acceptance. A new word is taken every cycle while the result register is
// empty or being drained (in_ch.ready = !out_ch.valid || out_ch.ready), so the
// sustained rate is one tick per clock while out_ch is not stalled. Configuration
// writes are always ready and must only be issued while no transaction is in
// progress.
module single_wire_sensor_reader #(
  parameter int MAX_BYTES = 8
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  swsr_in_if.sink     in_ch,
  swsr_out_if.source  out_ch,
  swsr_cfg_if.sink    cfg_ch
);
  import swsr_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_r;
  logic out_valid_r;
  logic in_ready;
  logic in_acc;

  assign in_ready     = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ready;
  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  swsr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_idx  (cfg_ch.index),
    .wr_data (cfg_ch.data),
    .cfg     (cfg)
  );

  swsr_seq #(
    .MAX_BYTES (MAX_BYTES)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (in_acc),
    .line_level    (in_ch.line_level),
    .start_request (in_ch.start_request),
    .cfg           (cfg),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) res_r <= res;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.drive_low       = res_r.drive_low;
  assign out_ch.busy_res        = res_r.busy_res;
  assign out_ch.status_valid    = res_r.status_valid;
  assign out_ch.response_status = res_r.response_status;
  assign out_ch.byte_valid      = res_r.byte_valid;
  assign out_ch.byte_value      = res_r.byte_value;
  assign out_ch.byte_last       = res_r.byte_last;

endmodule

`default_nettype wire

// ===== src/swsr_checker.sv =====
// Port-level checks for the sensor reader, bound to the top level.
`default_nettype none

module swsr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       drive_low,
  input wire logic       busy_res,
  input wire logic       status_valid,
  input wire logic [1:0] response_status,
  input wire logic       byte_valid,
  input wire logic [7:0] byte_value,
  input wire logic       byte_last
);
  import swsr_pkg::*;

  // an accepted tick always produces a result word next cycle
  a_acc_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(byte_value) && $stable(busy_res))
    else $error("stalled result changed");

  // the start pulse only happens inside a transaction
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && drive_low |-> busy_res)
    else $error("line driven while idle");

  // the final byte ends the transaction
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && byte_valid && byte_last |-> !busy_res && !status_valid)
    else $error("busy after final byte");

  // a fault or no-response status ends the transaction
  a_fail_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status_valid && (response_status == STAT_NONE ||
      response_status == STAT_FAULT) |-> !busy_res && !byte_valid)
    else $error("busy after failed response");

endmodule

bind single_wire_sensor_reader swsr_checker u_swsr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .drive_low       (out_ch.drive_low),
  .busy_res        (out_ch.busy_res),
  .status_valid    (out_ch.status_valid),
  .response_status (out_ch.response_status),
  .byte_valid      (out_ch.byte_valid),
  .byte_value      (out_ch.byte_value),
  .byte_last       (out_ch.byte_last)
);

`default_nettype wire
